// ----- src/hgu_pkg.sv -----
// Package for the history gravity update block: field widths, op codes,
// command and status types shared by the front, back and top level.
// Depends on nothing.
package hgu_pkg;

    // Field widths of the request and response words.
    localparam int OP_W     = 2;
    localparam int MOVE_W   = 16;
    localparam int WEIGHT_W = 12;
    localparam int SCORE_W  = 32;

    // The table index starts above the low four bits of the move code.
    localparam int INDEX_SHIFT = 4;

    // Gravity divisor of 512 is a shift by nine with truncation toward zero.
    localparam int GRAVITY_SHIFT = 9;

    // Product of weight (zero extended) and score, and the update sum.
    localparam int PROD_W = SCORE_W + WEIGHT_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Op codes carried in the request word.
    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Saturation limits of a score.
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
    localparam logic signed [SUM_W-1:0]   SUM_MAX   = SUM_W'(SCORE_MAX);
    localparam logic signed [SUM_W-1:0]   SUM_MIN   = SUM_W'(SCORE_MIN);

    // Bias that makes an arithmetic shift round a negative product toward zero.
    localparam logic signed [PROD_W-1:0] GRAVITY_BIAS =
        PROD_W'((1 << GRAVITY_SHIFT) - 1);
    localparam logic signed [PROD_W-1:0] PROD_ZERO = '0;

    // Work classes decided by the front.
    typedef enum logic [1:0] {
        K_RECORD,
        K_READ,
        K_CLEAR,
        K_NONE
    } kind_t;

    // One classified command, without the table index.
    typedef struct packed {
        kind_t               kind;
        logic                matched;
        logic                capture;
        logic                last;
        logic [WEIGHT_W-1:0] weight;
    } cmd_t;

    // Status the back reports to the front.
    typedef struct packed {
        logic init_busy;
    } back_stat_t;

endpackage

// ----- src/hgu_req_if.sv -----
// Request channel interface: valid, ready and the fields of one request word.
// Depends on hgu_pkg for field widths.
interface hgu_req_if;
    logic                         valid;
    logic                         ready;
    logic [hgu_pkg::OP_W-1:0]     op;
    logic [hgu_pkg::MOVE_W-1:0]   move_word;
    logic                         is_capture;
    logic [hgu_pkg::MOVE_W-1:0]   cutoff_move;
    logic [hgu_pkg::WEIGHT_W-1:0] weight;
    logic                         last;

    modport source (
        output valid, op, move_word, is_capture, cutoff_move, weight, last,
        input  ready
    );
    modport sink (
        input  valid, op, move_word, is_capture, cutoff_move, weight, last,
        output ready
    );
endinterface

// ----- src/hgu_rsp_if.sv -----
// Response channel interface: valid, ready and the fields of one result word.
// Depends on hgu_pkg for field widths.
interface hgu_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [hgu_pkg::SCORE_W-1:0] score;
    logic                               matched;
    logic                               changed;

    modport source (
        output valid, score, matched, changed,
        input  ready
    );
    modport sink (
        input  valid, score, matched, changed,
        output ready
    );
endinterface

// ----- src/history_gravity_update.sv -----
// Top level of the history gravity update block: front, command queue and
// back joined behind the request and response channels.
// Depends on hgu_pkg, hgu_req_if, hgu_rsp_if, hgu_front and hgu_back.
//
//   Channel  Role    Word fields
//   req      sink    op, move_word, is_capture, cutoff_move, weight, last
//   rsp      source  score, matched, changed
//
// A record word that updates its entry passes through pop, read and multiply,
// and write; a read, or a record that leaves its entry alone, through pop and
// read; an unused op is answered at the pop. A clear is popped and then zeroes
// all 2**INDEX_BITS entries, one entry a cycle. After reset the same zeroing
// pass runs with req.ready low. The two-word command queue lets req keep taking
// words while rsp stalls.
module history_gravity_update #(
    parameter int INDEX_BITS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    hgu_req_if.sink    req,
    hgu_rsp_if.source  rsp
);

    hgu_pkg::back_stat_t     stat;
    hgu_pkg::cmd_t           head_cmd;
    logic [INDEX_BITS-1:0]   head_idx;
    logic                    head_valid;
    logic                    pop;

    hgu_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .stat       (stat),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_idx   (head_idx)
    );

    hgu_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_idx   (head_idx),
        .pop        (pop),
        .stat       (stat),
        .rsp        (rsp)
    );

endmodule

// ----- src/hgu_front.sv -----
// Front of the history gravity update block: accepts request words,
// classifies them and holds them in a short command queue for the back.
// Depends on hgu_pkg and hgu_req_if.
module hgu_front #(
    parameter int INDEX_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    hgu_req_if.sink                 req,
    input  hgu_pkg::back_stat_t     stat,
    input  logic                    pop,
    output logic                    head_valid,
    output hgu_pkg::cmd_t           head_cmd,
    output logic [INDEX_BITS-1:0]   head_idx
);

    hgu_pkg::cmd_t               q_cmd_reg [hgu_pkg::QUEUE_DEPTH];
    logic [INDEX_BITS-1:0]       q_idx_reg [hgu_pkg::QUEUE_DEPTH];
    logic [hgu_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [hgu_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [hgu_pkg::QCNT_W-1:0]  count_reg;

    hgu_pkg::cmd_t               new_cmd;
    logic [INDEX_BITS-1:0]       new_idx;
    logic                        push;
    logic                        do_pop;

    // Classify the incoming word.
    always_comb
    begin
        new_cmd.matched = (req.move_word == req.cutoff_move);
        new_cmd.capture = req.is_capture;
        new_cmd.last    = req.last;
        new_cmd.weight  = req.weight;
        unique case (req.op)
            hgu_pkg::OP_RECORD: new_cmd.kind = hgu_pkg::K_RECORD;
            hgu_pkg::OP_READ:   new_cmd.kind = hgu_pkg::K_READ;
            hgu_pkg::OP_CLEAR:  new_cmd.kind = hgu_pkg::K_CLEAR;
            default:            new_cmd.kind = hgu_pkg::K_NONE;
        endcase
    end

    // Table index: move bits above the low four, zero above index bit eleven.
    assign new_idx = INDEX_BITS'(req.move_word >> hgu_pkg::INDEX_SHIFT);

    // Handshake: take a word while there is room and the reset sweep is done.
    assign req.ready = (count_reg != hgu_pkg::QCNT_W'(hgu_pkg::QUEUE_DEPTH))
                       && !stat.init_busy;
    assign push      = req.valid && req.ready;
    assign do_pop    = pop && head_valid;

    assign head_valid = (count_reg != '0);
    assign head_cmd   = q_cmd_reg[rd_ptr_reg];
    assign head_idx   = q_idx_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd_reg[wr_ptr_reg] <= new_cmd;
            q_idx_reg[wr_ptr_reg] <= new_idx;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    // No word may enter the queue while the table is still being cleared.
    a_no_fill_during_init: assert property (
        @(posedge clk) disable iff (!rst_n)
        stat.init_busy |-> (count_reg == '0)
    ) else $error("command queue filled during reset sweep");

    // The fill count never exceeds the queue depth.
    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= hgu_pkg::QCNT_W'(hgu_pkg::QUEUE_DEPTH)
    ) else $error("command queue overflow");
`endif

endmodule

// ----- src/hgu_back.sv -----
// Back of the history gravity update block: owns the score table, the
// cutoff flag and the response register, and carries out one command at a time.
// Depends on hgu_pkg and hgu_rsp_if.
module hgu_back #(
    parameter int INDEX_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  hgu_pkg::cmd_t           head_cmd,
    input  logic [INDEX_BITS-1:0]   head_idx,
    output logic                    pop,
    output hgu_pkg::back_stat_t     stat,
    hgu_rsp_if.source               rsp
);

    localparam int DEPTH = 1 << INDEX_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_CLEAR
    } state_t;

    state_t                              state_reg;
    logic                                init_reg;
    logic                                cutoff_seen_reg;
    logic [INDEX_BITS-1:0]               sweep_reg;
    hgu_pkg::cmd_t                       cur_cmd_reg;
    logic [INDEX_BITS-1:0]               cur_idx_reg;
    logic                                upd_reg;
    logic signed [hgu_pkg::SCORE_W-1:0]  entry_reg;
    logic signed [hgu_pkg::PROD_W-1:0]   prod_reg;
    logic signed [hgu_pkg::SCORE_W-1:0]  rdata_reg;
    logic                                out_valid_reg;
    logic signed [hgu_pkg::SCORE_W-1:0]  score_reg;
    logic                                matched_reg;
    logic                                changed_reg;

    logic signed [hgu_pkg::SCORE_W-1:0]  mem [DEPTH];

    logic                                out_free;
    logic                                mem_we;
    logic [INDEX_BITS-1:0]               mem_waddr;
    logic signed [hgu_pkg::SCORE_W-1:0]  mem_wdata;
    logic signed [hgu_pkg::PROD_W-1:0]   prod_next;
    logic signed [hgu_pkg::PROD_W-1:0]   prod_adj;
    logic signed [hgu_pkg::PROD_W-1:0]   term;
    logic signed [hgu_pkg::SUM_W-1:0]    e_ext;
    logic signed [hgu_pkg::SUM_W-1:0]    w_ext;
    logic signed [hgu_pkg::SUM_W-1:0]    t_ext;
    logic signed [hgu_pkg::SUM_W-1:0]    new_sum;
    logic signed [hgu_pkg::SCORE_W-1:0]  new_score;

    // The response register is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || rsp.ready;
    assign pop      = (state_reg == S_IDLE) && head_valid && out_free;

    assign stat.init_busy = init_reg;

    assign rsp.valid   = out_valid_reg;
    assign rsp.score   = score_reg;
    assign rsp.matched = matched_reg;
    assign rsp.changed = changed_reg;

    // Weight times entry, taken from the freshly read table word.
    assign prod_next = $signed({1'b0, cur_cmd_reg.weight}) * rdata_reg;

    // Divide by 512 truncating toward zero, then apply the bonus or penalty and saturate.
    always_comb
    begin
        prod_adj = prod_reg + (prod_reg[hgu_pkg::PROD_W-1] ? hgu_pkg::GRAVITY_BIAS
                                                           : hgu_pkg::PROD_ZERO);
        term  = prod_adj >>> hgu_pkg::GRAVITY_SHIFT;
        e_ext = hgu_pkg::SUM_W'(entry_reg);
        w_ext = $signed(hgu_pkg::SUM_W'(cur_cmd_reg.weight));
        t_ext = hgu_pkg::SUM_W'(term);
        if (cur_cmd_reg.matched)
        begin
            new_sum = e_ext + w_ext - t_ext;
        end
        else
        begin
            new_sum = e_ext - w_ext - t_ext;
        end
        priority if (new_sum > hgu_pkg::SUM_MAX)
        begin
            new_score = hgu_pkg::SCORE_MAX;
        end
        else if (new_sum < hgu_pkg::SUM_MIN)
        begin
            new_score = hgu_pkg::SCORE_MIN;
        end
        else
        begin
            new_score = new_sum[hgu_pkg::SCORE_W-1:0];
        end
    end

    // Table write port: the sweep writes zero, an update writes the new score.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_idx_reg;
        mem_wdata = new_score;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_WRITE)
        begin
            mem_we = 1'b1;
        end
    end

    // Score table with a registered read port addressed by the queue head.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            rdata_reg <= mem[head_idx];
        end
    end

    // Sequencer, cutoff flag and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            init_reg        <= 1'b1;
            cutoff_seen_reg <= 1'b0;
            sweep_reg       <= '0;
            cur_cmd_reg     <= '0;
            cur_idx_reg     <= '0;
            upd_reg         <= 1'b0;
            entry_reg       <= '0;
            prod_reg        <= '0;
            out_valid_reg   <= 1'b0;
            score_reg       <= '0;
            matched_reg     <= 1'b0;
            changed_reg     <= 1'b0;
        end
        else
        begin
            if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        cur_cmd_reg <= head_cmd;
                        cur_idx_reg <= head_idx;
                        upd_reg     <= (head_cmd.kind == hgu_pkg::K_RECORD)
                                       && !cutoff_seen_reg
                                       && (head_cmd.matched || !head_cmd.capture);
                        unique case (head_cmd.kind)
                            hgu_pkg::K_RECORD, hgu_pkg::K_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            hgu_pkg::K_CLEAR:
                            begin
                                cutoff_seen_reg <= 1'b0;
                                sweep_reg       <= '0;
                                out_valid_reg   <= 1'b1;
                                score_reg       <= '0;
                                matched_reg     <= 1'b0;
                                changed_reg     <= 1'b0;
                                state_reg       <= S_CLEAR;
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                                score_reg     <= '0;
                                matched_reg   <= 1'b0;
                                changed_reg   <= 1'b0;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    if (upd_reg)
                    begin
                        entry_reg <= rdata_reg;
                        prod_reg  <= prod_next;
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        score_reg     <= rdata_reg;
                        matched_reg   <= cur_cmd_reg.matched;
                        changed_reg   <= 1'b0;
                        if ((cur_cmd_reg.kind == hgu_pkg::K_RECORD) && cur_cmd_reg.last)
                        begin
                            cutoff_seen_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_WRITE:
                begin
                    out_valid_reg <= 1'b1;
                    score_reg     <= new_score;
                    matched_reg   <= cur_cmd_reg.matched;
                    changed_reg   <= 1'b1;
                    if (cur_cmd_reg.last)
                    begin
                        cutoff_seen_reg <= 1'b0;
                    end
                    else if (cur_cmd_reg.matched)
                    begin
                        cutoff_seen_reg <= 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == '1)
                    begin
                        init_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // A command is taken only by an idle sequencer.
    a_pop_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE)
    ) else $error("command popped while busy");

    // The response register is empty while a table read is in flight.
    a_read_out_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !out_valid_reg
    ) else $error("response register occupied during table read");

    // An update always presents its result in the next cycle.
    a_write_responds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (out_valid_reg && changed_reg)
    ) else $error("update produced no changed response");
`endif

endmodule
